[src/ps2mct_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int COORD_BITS = 13;
    localparam int SIZE_BITS  = 14;
    localparam int BTN_BITS   = 3;

    localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(768);

    localparam logic       REQ_PS2 = 1'b0;
    localparam logic       REQ_USB = 1'b1;

    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    localparam logic [7:0] AUX_FLAG = 8'h20;
    localparam logic [7:0] SYNC_BIT = 8'h08;
    localparam logic [7:0] BTN_MASK = 8'h07;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_XDELTA = 2'd1;
    localparam logic [1:0] PH_YDELTA = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic                    from_aux;
        logic [7:0]              data_byte;
        logic signed [7:0]       usb_dx;
        logic signed [7:0]       usb_dy;
        logic [BTN_BITS-1:0]     usb_buttons;
    } t_in_req;

    typedef struct packed {
        logic [COORD_BITS-1:0]   cursor_x;
        logic [COORD_BITS-1:0]   cursor_y;
        logic [BTN_BITS-1:0]     button_state;
        logic                    update_done;
        logic                    byte_dropped;
    } t_out_res;

endpackage

[src/ps2mct_axis.sv]
// ----------------------------------------------------------------------------
// ps2mct_axis
// One cursor axis: add a signed delta, clamp to the screen size, and
// give the centre position for that size.
// ----------------------------------------------------------------------------
module ps2mct_axis (
    input  logic [ps2mct_pkg::COORD_BITS-1:0] i_cur,
    input  logic signed [8:0]                 i_delta,
    input  logic [ps2mct_pkg::SIZE_BITS-1:0]  i_size,
    output logic [ps2mct_pkg::COORD_BITS-1:0] o_clamped,
    output logic [ps2mct_pkg::COORD_BITS-1:0] o_centre
);
    import ps2mct_pkg::*;

    localparam int EFF_W = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam int SUM_W = EFF_W + 2;
    localparam logic [EFF_W-1:0] LIM = EFF_W'(1) << COORD_BITS;

    logic [EFF_W-1:0]        size_ext;
    logic [EFF_W-1:0]        eff;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_s;

    always_comb begin
        size_ext = EFF_W'(i_size);
        if (size_ext == '0) begin
            eff = EFF_W'(1);
        end else if (size_ext > LIM) begin
            eff = LIM;
        end else begin
            eff = size_ext;
        end
        lim_s = signed'({2'b00, eff});
        sum   = signed'(SUM_W'(i_cur)) + SUM_W'(i_delta);
        if (sum < 0) begin
            o_clamped = '0;
        end else if (sum >= lim_s) begin
            o_clamped = COORD_BITS'(eff - EFF_W'(1));
        end else begin
            o_clamped = sum[COORD_BITS-1:0];
        end
        o_centre = eff[COORD_BITS:1];
    end

endmodule

[src/ps2_mouse_packet_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// PS/2 three-byte packet decoder and USB report handler with a clamped cursor.
// ----------------------------------------------------------------------------
// Every accepted request yields one result: the cursor and buttons after the
// request, plus flags for a completed update or a dropped byte. A new request
// may enter every cycle while the output register can take its result; the
// cursor add-and-clamp path of each axis sets the cycle. Results sit in one
// output register, so input ready stays high while that register is empty or
// being drained. Writing either screen size re-centres the cursor and restarts
// packet assembly; write sizes only while no request is in flight.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ps2mct_pkg::t_in_req               i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ps2mct_pkg::t_out_res              o_out_res,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [ps2mct_pkg::SIZE_BITS-1:0]  i_cfg_wdata
);
    import ps2mct_pkg::*;

    localparam int LIM_I = 1 << COORD_BITS;
    localparam int RW_I  = (int'(RESET_WIDTH)  > LIM_I) ? LIM_I : int'(RESET_WIDTH);
    localparam int RH_I  = (int'(RESET_HEIGHT) > LIM_I) ? LIM_I : int'(RESET_HEIGHT);
    localparam logic [COORD_BITS-1:0] RESET_CX = COORD_BITS'(RW_I / 2);
    localparam logic [COORD_BITS-1:0] RESET_CY = COORD_BITS'(RH_I / 2);

    logic [SIZE_BITS-1:0]  r_width,   n_width;
    logic [SIZE_BITS-1:0]  r_height,  n_height;
    logic [1:0]            r_phase,   n_phase;
    logic [7:0]            r_header,  n_header;
    logic [7:0]            r_xbyte,   n_xbyte;
    logic [COORD_BITS-1:0] r_cx,      n_cx;
    logic [COORD_BITS-1:0] r_cy,      n_cy;
    logic [BTN_BITS-1:0]   r_btn,     n_btn;
    logic                  r_out_valid, n_out_valid;
    t_out_res              r_out,     n_out;

    logic                  in_fire;
    logic signed [8:0]     dx, dy;
    logic [COORD_BITS-1:0] x_clamped, y_clamped, x_centre, y_centre;
    logic [BTN_BITS-1:0]   new_btn, chg;
    logic                  upd, dropped;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    always_comb begin
        if (i_in_req.req_type == REQ_USB) begin
            dx = 9'(i_in_req.usb_dx);
            dy = 9'(i_in_req.usb_dy);
        end else begin
            dx = 9'(signed'(r_xbyte));
            dy = -9'(signed'(i_in_req.data_byte));
        end
    end

    ps2mct_axis u_axis_x (
        .i_cur     (r_cx),
        .i_delta   (dx),
        .i_size    (n_width),
        .o_clamped (x_clamped),
        .o_centre  (x_centre)
    );

    ps2mct_axis u_axis_y (
        .i_cur     (r_cy),
        .i_delta   (dy),
        .i_size    (n_height),
        .o_clamped (y_clamped),
        .o_centre  (y_centre)
    );

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH:  n_width  = i_cfg_wdata;
                REG_HEIGHT: n_height = i_cfg_wdata;
                default:    n_width  = r_width;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_xbyte     = r_xbyte;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_btn       = r_btn;
        upd         = 1'b0;
        dropped     = 1'b0;
        new_btn     = BTN_BITS'(r_header & BTN_MASK);
        chg         = new_btn ^ r_btn;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cfg_we) begin
            n_cx    = x_centre;
            n_cy    = y_centre;
            n_phase = PH_HEADER;
        end else if (in_fire) begin
            if (i_in_req.req_type == REQ_USB) begin
                upd   = 1'b1;
                n_btn = i_in_req.usb_buttons;
            end else if (!i_in_req.from_aux) begin
                dropped = 1'b1;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if ((i_in_req.data_byte & SYNC_BIT) == '0) begin
                            dropped = 1'b1;
                        end else begin
                            n_header = i_in_req.data_byte;
                            n_phase  = PH_XDELTA;
                        end
                    end
                    PH_XDELTA: begin
                        n_xbyte = i_in_req.data_byte;
                        n_phase = PH_YDELTA;
                    end
                    default: begin
                        upd     = 1'b1;
                        n_phase = PH_HEADER;
                        if ((dx == '0 && dy == '0) || ((chg & (chg - 1'b1)) == '0)) begin
                            n_btn = new_btn;
                        end
                    end
                endcase
            end
            if (upd) begin
                n_cx = x_clamped;
                n_cy = y_clamped;
            end
            n_out_valid        = 1'b1;
            n_out.cursor_x     = n_cx;
            n_out.cursor_y     = n_cy;
            n_out.button_state = n_btn;
            n_out.update_done  = upd;
            n_out.byte_dropped = dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_phase     <= PH_HEADER;
            r_header    <= '0;
            r_xbyte     <= '0;
            r_cx        <= RESET_CX;
            r_cy        <= RESET_CY;
            r_btn       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_phase     <= n_phase;
            r_header    <= n_header;
            r_xbyte     <= n_xbyte;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_btn       <= n_btn;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
